// ===== sv/chunk_pool_suballocator_macros.svh =====
// Assertion macros for the file that checks this block.
`ifndef CHUNK_POOL_SUBALLOCATOR_MACROS_SVH
`define CHUNK_POOL_SUBALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/cps_pkg.sv =====
`timescale 1ns / 1ps
package cps_pkg;

    localparam int MAX_CHUNKS_DEF = 16;
    localparam int ID_W_DEF = $clog2(MAX_CHUNKS_DEF);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RESOLVE = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_LIST = 2'd1;
    localparam logic [1:0] ST_EXHAUST = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] CFG_SCRATCH  = 2'd0;
    localparam logic [1:0] CFG_DEF_SIZE = 2'd1;
    localparam logic [1:0] CFG_LIMIT    = 2'd2;
    localparam logic [1:0] CFG_ALIGN    = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [39:0] request_size;
        logic [4:0]  align_log2;
        logic [31:0] version;
        logic [31:0] completed_instance;
        logic        has_command_list;
        logic        want_ticket;
        logic [3:0]  target_chunk;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  chunk_index;
        logic [39:0] alloc_offset;
        logic        new_chunk;
        logic [39:0] new_chunk_size;
        logic        uav_barrier;
    } t_out;

    typedef enum logic [1:0] {TICK_KEEP, TICK_INC, TICK_DEC, TICK_CLEAR} t_tick_op;
    typedef enum logic [1:0] {POOL_HOLD, POOL_RIGHT, POOL_HEAD, POOL_NEW} t_pool_op;
    typedef enum logic [1:0] {PC_NONE, PC_ROT, PC_DROP, PC_APPEND} t_pool_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ALIGN, S_BUMP, S_SCAN, S_APPEND,
        S_SIZE, S_LIMIT, S_BEST, S_REMOVE, S_TAKE
    } t_state;

    typedef struct packed {
        logic [39:0] bytes;
        logic [39:0] wp;
        logic [31:0] ver;
        logic [15:0] tick;
    } t_chunk;

    typedef struct packed {
        logic        en;
        logic        we_bytes;
        logic [39:0] bytes;
        logic        we_wp;
        logic [39:0] wp;
        logic        we_ver;
        logic [31:0] ver;
        t_tick_op    tick;
    } t_chunk_wr;

endpackage

// ===== sv/cps_chunk_cell.sv =====
`timescale 1ns / 1ps
module cps_chunk_cell (
    input  logic               i_clk,
    input  logic               i_sel,
    input  cps_pkg::t_chunk_wr i_wr,
    output cps_pkg::t_chunk    o_state
);
    import cps_pkg::*;

    t_chunk r_state;

    always_ff @(posedge i_clk) begin
        if (i_sel) begin
            if (i_wr.we_bytes) begin
                r_state.bytes <= i_wr.bytes;
            end
            if (i_wr.we_wp) begin
                r_state.wp <= i_wr.wp;
            end
            if (i_wr.we_ver) begin
                r_state.ver <= i_wr.ver;
            end
            case (i_wr.tick)
                TICK_INC: begin
                    if (r_state.tick != 16'hFFFF) begin
                        r_state.tick <= r_state.tick + 16'd1;
                    end
                end
                TICK_DEC: begin
                    if (r_state.tick != 16'd0) begin
                        r_state.tick <= r_state.tick - 16'd1;
                    end
                end
                TICK_CLEAR: begin
                    r_state.tick <= 16'd0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_state = r_state;
endmodule

// ===== sv/cps_pool_cell.sv =====
`timescale 1ns / 1ps
module cps_pool_cell #(
    parameter int ID_W = cps_pkg::ID_W_DEF
) (
    input  logic              i_clk,
    input  cps_pkg::t_pool_op i_op,
    input  logic [ID_W-1:0]   i_right,
    input  logic [ID_W-1:0]   i_head,
    input  logic [ID_W-1:0]   i_new,
    output logic [ID_W-1:0]   o_id
);
    import cps_pkg::*;

    logic [ID_W-1:0] r_id;

    always_ff @(posedge i_clk) begin
        case (i_op)
            POOL_RIGHT: begin
                r_id <= i_right;
            end
            POOL_HEAD: begin
                r_id <= i_head;
            end
            POOL_NEW: begin
                r_id <= i_new;
            end
            default: begin
            end
        endcase
    end

    assign o_id = r_id;
endmodule

// ===== sv/chunk_pool_suballocator.sv =====
`timescale 1ns / 1ps
// One command at a time; the registered result strobe comes in the cycle after the
// last step. Resolve, release, an unknown command or a missing command list end in
// the decode step; a bump hit passes decode, align and bump; a miss scans the pool
// chain, rotating one entry per cycle per pass, with no stall. The next command may
// start in the cycle of the result strobe, and the receiver cannot stall the result.
// Synchronous active-low reset clears the counts and the current chunk and restores
// the configuration defaults.
`include "chunk_pool_suballocator_macros.svh"
module chunk_pool_suballocator #(
    parameter int MAX_CHUNKS = cps_pkg::MAX_CHUNKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  cps_pkg::t_in                   i_in,
    output logic                           o_valid,
    output cps_pkg::t_out                  o_out,
    input  logic                           i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cps_pkg::*;

    localparam int CW = $clog2(MAX_CHUNKS);
    localparam int NW = $clog2(MAX_CHUNKS + 1);

    t_state r_state, n_state;
    t_in    r_in, n_in;
    t_out   r_out, n_out;
    logic   r_out_valid, n_out_valid;

    logic        r_cfg_scratch;
    logic [39:0] r_cfg_def;
    logic [39:0] r_cfg_lim;
    logic [4:0]  r_cfg_salign;

    logic [NW-1:0] r_pool_cnt, n_pool_cnt;
    logic [NW-1:0] r_chunk_cnt, n_chunk_cnt;
    logic [NW-1:0] r_steps, n_steps;
    logic          r_cur_valid, n_cur_valid;
    logic [CW-1:0] r_cur, n_cur;
    logic [39:0]   r_alloc, n_alloc;
    logic [41:0]   r_aligned, n_aligned;
    logic          r_retire_valid, n_retire_valid;
    logic [CW-1:0] r_retire, n_retire;
    logic          r_found, n_found;
    logic [CW-1:0] r_pick, n_pick;
    logic [40:0]   r_want, n_want;
    logic          r_best_valid, n_best_valid;
    logic [CW-1:0] r_best, n_best;
    logic [31:0]   r_best_ver, n_best_ver;
    logic [39:0]   r_best_bytes, n_best_bytes;
    logic          r_nc, n_nc;
    logic          r_bar, n_bar;

    t_chunk    w_chunk [MAX_CHUNKS];
    logic [CW-1:0] w_pool_id [MAX_CHUNKS];
    logic [CW-1:0] w_right [MAX_CHUNKS];
    t_pool_op  w_pool_op [MAX_CHUNKS];
    t_pool_cmd w_pool_cmd;
    t_chunk_wr w_wr;
    logic [CW-1:0] w_wr_id;

    t_chunk      w_cur, w_head, w_tgt;
    logic [CW-1:0] w_head_id;
    logic [41:0] w_amask, w_end;
    logic        w_fit, w_missing, w_t_ok;
    logic [31:0] w_hver_clr;
    logic        w_fit_elig, w_best_elig, w_better;
    logic [39:0] w_size_max;
    logic [40:0] w_gmask, w_sum;
    logic        w_over_limit, w_table_full, w_pool_room;

    for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_cells
        if (g == MAX_CHUNKS - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_mid
            assign w_right[g] = w_pool_id[g+1];
        end
        cps_chunk_cell u_chunk (
            .i_clk   (i_clk),
            .i_sel   (w_wr.en && (w_wr_id == CW'(g))),
            .i_wr    (w_wr),
            .o_state (w_chunk[g])
        );
        cps_pool_cell #(.ID_W(CW)) u_pool (
            .i_clk   (i_clk),
            .i_op    (w_pool_op[g]),
            .i_right (w_right[g]),
            .i_head  (w_pool_id[0]),
            .i_new   (r_retire),
            .o_id    (w_pool_id[g])
        );
    end

    assign w_head_id  = w_pool_id[0];
    assign w_cur      = w_chunk[r_cur];
    assign w_head     = w_chunk[w_head_id];
    assign w_tgt      = w_chunk[CW'(r_in.target_chunk)];
    assign w_amask    = (42'd1 << r_in.align_log2) - 42'd1;
    assign w_end      = r_aligned + 42'(r_in.request_size);
    assign w_fit      = w_end <= 42'(w_cur.bytes);
    assign w_missing  = r_cfg_scratch && !r_in.has_command_list;
    assign w_t_ok     = (32'(r_in.target_chunk) < 32'(r_chunk_cnt))
                        && (32'(r_in.target_chunk) < 32'(MAX_CHUNKS));
    assign w_hver_clr = (w_head.ver != 32'd0 && w_head.ver <= r_in.completed_instance)
                        ? 32'd0 : w_head.ver;
    assign w_fit_elig = (w_head.tick == 16'd0) && (w_hver_clr == 32'd0)
                        && (w_head.bytes >= r_in.request_size);
    assign w_best_elig = (w_head.tick == 16'd0) && (41'(w_head.bytes) >= r_want);
    assign w_better   = !r_best_valid || (w_head.ver < r_best_ver)
                        || (w_head.ver == r_best_ver && w_head.bytes > r_best_bytes);
    assign w_size_max = (r_in.request_size > r_cfg_def) ? r_in.request_size : r_cfg_def;
    assign w_gmask    = (41'd1 << r_cfg_salign) - 41'd1;
    assign w_sum      = 41'(r_alloc) + r_want;
    assign w_over_limit = (r_cfg_lim != 40'd0) && (w_sum > 41'(r_cfg_lim));
    assign w_table_full = r_chunk_cnt >= NW'(MAX_CHUNKS);
    assign w_pool_room  = r_pool_cnt < NW'(MAX_CHUNKS);

    always_comb begin
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            w_pool_op[i] = POOL_HOLD;
            case (w_pool_cmd)
                PC_ROT: begin
                    if (i + 1 < int'(r_pool_cnt)) begin
                        w_pool_op[i] = POOL_RIGHT;
                    end else if (i + 1 == int'(r_pool_cnt)) begin
                        w_pool_op[i] = POOL_HEAD;
                    end
                end
                PC_DROP: begin
                    if (i + 1 < int'(r_pool_cnt)) begin
                        w_pool_op[i] = POOL_RIGHT;
                    end
                end
                PC_APPEND: begin
                    if (i == int'(r_pool_cnt)) begin
                        w_pool_op[i] = POOL_NEW;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_in.cmd == CMD_ALLOC && !w_missing) begin
                    n_state = r_cur_valid ? S_ALIGN : S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ALIGN: begin
                n_state = S_BUMP;
            end
            S_BUMP: begin
                n_state = w_fit ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (r_steps == '0) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                n_state = r_found ? S_TAKE : S_SIZE;
            end
            S_SIZE: begin
                n_state = S_LIMIT;
            end
            S_LIMIT: begin
                if (r_want[40]) begin
                    n_state = S_IDLE;
                end else if (w_over_limit) begin
                    n_state = r_cfg_scratch ? S_BEST : S_IDLE;
                end else begin
                    n_state = w_table_full ? S_IDLE : S_TAKE;
                end
            end
            S_BEST: begin
                if (r_steps == '0) begin
                    n_state = r_best_valid ? S_REMOVE : S_IDLE;
                end
            end
            S_REMOVE: begin
                if (r_steps == '0) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_in           = r_in;
        n_out          = r_out;
        n_out_valid    = 1'b0;
        n_pool_cnt     = r_pool_cnt;
        n_chunk_cnt    = r_chunk_cnt;
        n_steps        = r_steps;
        n_cur_valid    = r_cur_valid;
        n_cur          = r_cur;
        n_alloc        = r_alloc;
        n_aligned      = r_aligned;
        n_retire_valid = r_retire_valid;
        n_retire       = r_retire;
        n_found        = r_found;
        n_pick         = r_pick;
        n_want         = r_want;
        n_best_valid   = r_best_valid;
        n_best         = r_best;
        n_best_ver     = r_best_ver;
        n_best_bytes   = r_best_bytes;
        n_nc           = r_nc;
        n_bar          = r_bar;
        w_wr           = '0;
        w_wr_id        = '0;
        w_pool_cmd     = PC_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in           = i_in;
                    n_found        = 1'b0;
                    n_retire_valid = 1'b0;
                    n_nc           = 1'b0;
                    n_bar          = 1'b0;
                    n_best_valid   = 1'b0;
                end
            end
            S_DECODE: begin
                if (r_in.cmd == CMD_ALLOC) begin
                    if (w_missing) begin
                        n_out        = '0;
                        n_out.status = ST_NO_LIST;
                        n_out_valid  = 1'b1;
                    end else begin
                        n_steps = r_pool_cnt;
                    end
                end else if (r_in.cmd == CMD_RESOLVE || r_in.cmd == CMD_RELEASE) begin
                    w_wr_id = CW'(r_in.target_chunk);
                    w_wr.en = w_t_ok;
                    if (r_in.cmd == CMD_RESOLVE) begin
                        w_wr.we_ver = r_in.version > w_tgt.ver;
                        w_wr.ver    = r_in.version;
                    end else begin
                        w_wr.tick = TICK_DEC;
                    end
                    n_out             = '0;
                    n_out.chunk_index = r_in.target_chunk;
                    n_out_valid       = 1'b1;
                end else begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                end
            end
            S_ALIGN: begin
                n_aligned = (42'(w_cur.wp) + w_amask) & ~w_amask;
            end
            S_BUMP: begin
                if (w_fit) begin
                    w_wr_id     = r_cur;
                    w_wr.en     = 1'b1;
                    w_wr.we_wp  = 1'b1;
                    w_wr.wp     = w_end[39:0];
                    w_wr.we_ver = r_in.version > w_cur.ver;
                    w_wr.ver    = r_in.version;
                    w_wr.tick   = r_in.want_ticket ? TICK_INC : TICK_KEEP;
                    n_out              = '0;
                    n_out.status       = ST_OK;
                    n_out.chunk_index  = 4'(r_cur);
                    n_out.alloc_offset = r_aligned[39:0];
                    n_out_valid        = 1'b1;
                end else begin
                    n_retire_valid = 1'b1;
                    n_retire       = r_cur;
                    n_cur_valid    = 1'b0;
                    n_steps        = r_pool_cnt;
                end
            end
            S_SCAN: begin
                if (r_steps != '0) begin
                    n_steps = r_steps - NW'(1);
                    if (!r_found) begin
                        w_wr_id     = w_head_id;
                        w_wr.en     = 1'b1;
                        w_wr.we_ver = 1'b1;
                        w_wr.ver    = w_hver_clr;
                        if (w_fit_elig) begin
                            w_pool_cmd = PC_DROP;
                            n_pool_cnt = r_pool_cnt - NW'(1);
                            n_found    = 1'b1;
                            n_pick     = w_head_id;
                        end else begin
                            w_pool_cmd = PC_ROT;
                        end
                    end else begin
                        w_pool_cmd = PC_ROT;
                    end
                end
            end
            S_APPEND: begin
                if (r_retire_valid && w_pool_room) begin
                    w_pool_cmd = PC_APPEND;
                    n_pool_cnt = r_pool_cnt + NW'(1);
                end
                n_retire_valid = 1'b0;
            end
            S_SIZE: begin
                n_want = (41'(w_size_max) + w_gmask) & ~w_gmask;
            end
            S_LIMIT: begin
                if (r_want[40] || (w_over_limit && !r_cfg_scratch)) begin
                    n_out        = '0;
                    n_out.status = ST_EXHAUST;
                    n_out_valid  = 1'b1;
                end else if (w_over_limit) begin
                    n_steps      = r_pool_cnt;
                    n_best_valid = 1'b0;
                end else if (w_table_full) begin
                    n_out        = '0;
                    n_out.status = ST_FULL;
                    n_out_valid  = 1'b1;
                end else begin
                    w_wr_id       = CW'(r_chunk_cnt);
                    w_wr.en       = 1'b1;
                    w_wr.we_bytes = 1'b1;
                    w_wr.bytes    = r_want[39:0];
                    w_wr.tick     = TICK_CLEAR;
                    n_pick        = CW'(r_chunk_cnt);
                    n_chunk_cnt   = r_chunk_cnt + NW'(1);
                    n_alloc       = w_sum[40] ? '1 : w_sum[39:0];
                    n_nc          = 1'b1;
                end
            end
            S_BEST: begin
                if (r_steps != '0) begin
                    n_steps    = r_steps - NW'(1);
                    w_pool_cmd = PC_ROT;
                    if (w_best_elig && w_better) begin
                        n_best_valid = 1'b1;
                        n_best       = w_head_id;
                        n_best_ver   = w_head.ver;
                        n_best_bytes = w_head.bytes;
                    end
                end else if (r_best_valid) begin
                    n_steps = r_pool_cnt;
                end else begin
                    n_out        = '0;
                    n_out.status = ST_EXHAUST;
                    n_out_valid  = 1'b1;
                end
            end
            S_REMOVE: begin
                if (r_steps != '0) begin
                    n_steps = r_steps - NW'(1);
                    if (w_head_id == r_best) begin
                        w_pool_cmd = PC_DROP;
                        n_pool_cnt = r_pool_cnt - NW'(1);
                    end else begin
                        w_pool_cmd = PC_ROT;
                    end
                end else begin
                    n_pick = r_best;
                    n_bar  = 1'b1;
                end
            end
            S_TAKE: begin
                n_cur_valid = 1'b1;
                n_cur       = r_pick;
                w_wr_id     = r_pick;
                w_wr.en     = 1'b1;
                w_wr.we_ver = 1'b1;
                w_wr.ver    = r_in.version;
                w_wr.we_wp  = 1'b1;
                w_wr.wp     = r_in.request_size;
                w_wr.tick   = r_in.want_ticket ? TICK_INC : TICK_KEEP;
                n_out                = '0;
                n_out.status         = ST_OK;
                n_out.chunk_index    = 4'(r_pick);
                n_out.new_chunk      = r_nc;
                n_out.new_chunk_size = r_nc ? r_want[39:0] : 40'd0;
                n_out.uav_barrier    = r_bar;
                n_out_valid          = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_scratch <= 1'b0;
            r_cfg_def     <= 40'd16777216;
            r_cfg_lim     <= 40'd0;
            r_cfg_salign  <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCRATCH:  r_cfg_scratch <= i_cfg_data[0];
                CFG_DEF_SIZE: r_cfg_def     <= i_cfg_data[39:0];
                CFG_LIMIT:    r_cfg_lim     <= i_cfg_data[39:0];
                CFG_ALIGN:    r_cfg_salign  <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_pool_cnt     <= '0;
            r_chunk_cnt    <= '0;
            r_steps        <= '0;
            r_cur_valid    <= 1'b0;
            r_cur          <= '0;
            r_alloc        <= '0;
            r_retire_valid <= 1'b0;
            r_found        <= 1'b0;
            r_best_valid   <= 1'b0;
            r_nc           <= 1'b0;
            r_bar          <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_pool_cnt     <= n_pool_cnt;
            r_chunk_cnt    <= n_chunk_cnt;
            r_steps        <= n_steps;
            r_cur_valid    <= n_cur_valid;
            r_cur          <= n_cur;
            r_alloc        <= n_alloc;
            r_retire_valid <= n_retire_valid;
            r_found        <= n_found;
            r_best_valid   <= n_best_valid;
            r_nc           <= n_nc;
            r_bar          <= n_bar;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_out        <= n_out;
        r_aligned    <= n_aligned;
        r_retire     <= n_retire;
        r_pick       <= n_pick;
        r_want       <= n_want;
        r_best       <= n_best;
        r_best_ver   <= n_best_ver;
        r_best_bytes <= n_best_bytes;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    `CPS_ASSERT_IMP(a_strobe_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `CPS_ASSERT_NXT(a_start_goes_busy, i_clk, i_rst_n, start && !busy, busy)
    `CPS_ASSERT_IMP(a_pool_within_table, i_clk, i_rst_n, 1'b1, r_pool_cnt <= r_chunk_cnt)
    `CPS_ASSERT_IMP(a_fail_fields_zero, i_clk, i_rst_n, o_valid && o_out.status != ST_OK, o_out.alloc_offset == 40'd0 && !o_out.new_chunk && !o_out.uav_barrier)
endmodule
